// ----- hdl/bfpa_pkg.sv -----
package bfpa_pkg;

   localparam int MAX_CHUNKS = 16;
   localparam int PAGE_BITS  = 20;
   localparam int CNT_BITS   = PAGE_BITS + 1;
   localparam int IDX_BITS   = $clog2(MAX_CHUNKS);
   localparam int ENT_BITS   = $clog2(MAX_CHUNKS + 1);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_NOMEM   = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
      logic [CNT_BITS-1:0] size;
      logic [PAGE_BITS-1:0] base;
   } best_type;

   typedef struct packed {
      logic                apply;
      logic                is_free;
      logic                exact;
      logic [IDX_BITS-1:0] pick;
      logic [CNT_BITS-1:0] cnt;
      logic [ENT_BITS-1:0] entries;
   } ctl_type;

endpackage

// ----- hdl/bfpa_req_if.sv -----
interface bfpa_req_if;
   import bfpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [CNT_BITS-1:0]  page_count;
   logic [PAGE_BITS-1:0] page_number;
   modport source (output valid, mode, page_count, page_number, input ready);
   modport sink   (input valid, mode, page_count, page_number, output ready);
endinterface

// ----- hdl/bfpa_rsp_if.sv -----
interface bfpa_rsp_if;
   import bfpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [PAGE_BITS-1:0] granted_page;
   logic [CNT_BITS-1:0]  total_free;
   modport source (output valid, status, granted_page, total_free, input ready);
   modport sink   (input valid, status, granted_page, total_free, output ready);
endinterface

// ----- hdl/bfpa_cell.sv -----
module bfpa_cell (
   input  logic                          clock,
   input  bfpa_pkg::ctl_type             ctl,
   input  logic [bfpa_pkg::IDX_BITS-1:0] idx,
   input  logic [bfpa_pkg::PAGE_BITS-1:0] prev_base,
   input  logic [bfpa_pkg::CNT_BITS-1:0]  prev_size,
   input  logic [bfpa_pkg::PAGE_BITS-1:0] next_base,
   input  logic [bfpa_pkg::CNT_BITS-1:0]  next_size,
   input  bfpa_pkg::best_type            best_in,
   output bfpa_pkg::best_type            best_out,
   output logic [bfpa_pkg::PAGE_BITS-1:0] base_out,
   output logic [bfpa_pkg::CNT_BITS-1:0]  size_out
);
   import bfpa_pkg::*;

   logic [PAGE_BITS-1:0] base_ff, base_in;
   logic [CNT_BITS-1:0]  size_ff, size_in;
   best_type             best_ff;
   logic                 occ, fits;

   assign occ  = {1'b0, idx} < ENT_BITS'(ctl.entries);
   assign fits = occ && (size_ff >= ctl.cnt);

   always_comb begin
      if (fits && (!best_ff.found || size_ff < best_ff.size)) begin
         best_out = '{found: 1'b1, idx: idx, size: size_ff, base: base_ff};
      end else begin
         best_out = best_ff;
      end
   end

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      if (ctl.apply) begin
         if (ctl.is_free) begin
            base_in = prev_base;
            size_in = prev_size;
         end else if (ctl.exact) begin
            if (idx >= ctl.pick) begin
               base_in = next_base;
               size_in = next_size;
            end
         end else if (idx == ctl.pick) begin
            size_in = size_ff - ctl.cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      size_ff <= size_in;
      best_ff <= best_in;
   end

   assign base_out = base_ff;
   assign size_out = size_ff;
endmodule

// ----- hdl/best_fit_page_allocator_top.sv -----
// Best-fit page allocator.
// req_bus carries one transaction per request: mode 0 allocates page_count
// pages, mode 1 frees page_count pages starting at page_number.
// rsp_bus returns one transaction per request with status, granted page
// and the total of free pages after the request.
// The free list sits in a row of MAX_CHUNKS cells. An allocation sends the
// best-fit search down the row one cell per cycle in state S_SEARCH, and then
// S_APPLY loads its response register; a free, or a request with zero count,
// goes straight from S_IDLE to S_APPLY. A new request is taken only after
// S_APPLY has gone back to S_IDLE. One request is worked on at a time.
// A response waits in its register while the receiver stalls; the next
// request is still accepted and its update waits until that register frees.
// Reset (synchronous, active high) empties the list and clears the total;
// cell contents are not cleared.
module best_fit_page_allocator_top (
   input logic        clock,
   input logic        reset,
   bfpa_req_if.sink   req_bus,
   bfpa_rsp_if.source rsp_bus
);
   import bfpa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_APPLY  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [ENT_BITS-1:0]  scan_ff, scan_in;
   logic [ENT_BITS-1:0]  entries_ff, entries_in;
   logic [CNT_BITS-1:0]  sum_ff, sum_in;
   logic                 mode_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;
   logic [PAGE_BITS-1:0] grant_ff, grant_in;
   logic [CNT_BITS-1:0]  total_ff;

   logic      accept, go;
   ctl_type   ctl;
   best_type  best [MAX_CHUNKS+1];
   logic [PAGE_BITS-1:0] cbase [MAX_CHUNKS];
   logic [CNT_BITS-1:0]  csize [MAX_CHUNKS];
   logic [CNT_BITS:0]    free_total;
   logic                 ok;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign go            = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_bus.ready);
   assign free_total    = {1'b0, cnt_ff} + {1'b0, sum_ff};
   assign best[0]       = '0;
   assign ctl.exact     = best[MAX_CHUNKS].size == cnt_ff;

   always_comb begin
      status_in = ST_OK;
      grant_in  = '0;
      if (mode_ff) begin
         if (cnt_ff == '0 || page_ff == '0 ||
             free_total > (CNT_BITS+1)'(1) << PAGE_BITS) begin
            status_in = ST_IGNORED;
         end else if (entries_ff == ENT_BITS'(MAX_CHUNKS)) begin
            status_in = ST_FULL;
         end
      end else if (cnt_ff == '0) begin
         status_in = ST_IGNORED;
      end else if (!best[MAX_CHUNKS].found) begin
         status_in = ST_NOMEM;
      end else if (ctl.exact) begin
         grant_in = best[MAX_CHUNKS].base;
      end else begin
         grant_in = best[MAX_CHUNKS].base
                  + PAGE_BITS'(best[MAX_CHUNKS].size - cnt_ff);
      end
   end

   assign ok          = status_in == ST_OK;
   assign ctl.apply   = go && ok;
   assign ctl.is_free = mode_ff;
   assign ctl.pick    = best[MAX_CHUNKS].idx;
   assign ctl.cnt     = cnt_ff;
   assign ctl.entries = entries_ff;

   genvar g;
   generate
      for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
         bfpa_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .idx       (IDX_BITS'(g)),
            .prev_base ((g == 0) ? page_ff : cbase[(g == 0) ? 0 : g-1]),
            .prev_size ((g == 0) ? cnt_ff  : csize[(g == 0) ? 0 : g-1]),
            .next_base (cbase[(g == MAX_CHUNKS-1) ? g : g+1]),
            .next_size (csize[(g == MAX_CHUNKS-1) ? g : g+1]),
            .best_in   (best[g]),
            .best_out  (best[g+1]),
            .base_out  (cbase[g]),
            .size_out  (csize[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      entries_in   = entries_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            if (accept) begin
               if (!req_bus.mode && req_bus.page_count != '0) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_SEARCH: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == ENT_BITS'(MAX_CHUNKS - 1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (ok) begin
                  if (mode_ff) begin
                     entries_in = entries_ff + 1'b1;
                     sum_in     = sum_ff + cnt_ff;
                  end else begin
                     sum_in = sum_ff - cnt_ff;
                     if (ctl.exact) begin
                        entries_in = entries_ff - 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         entries_ff   <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         entries_ff   <= entries_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_bus.mode;
         cnt_ff  <= req_bus.page_count;
         page_ff <= req_bus.page_number;
      end
      if (go) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         total_ff  <= sum_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.granted_page = grant_ff;
   assign rsp_bus.total_free   = total_ff;
endmodule
